>>> rtl/cspc_pkg.sv
// Shared types and constants for the CO2 sensor poll controller.
`timescale 1ns / 1ps

package cspc_pkg;

   // Sensor command words.
   localparam logic [15:0] CMD_START = 16'h21B1;
   localparam logic [15:0] CMD_READ  = 16'hEC05;
   localparam logic [15:0] CMD_STOP  = 16'h3F86;

   // Mode codes.
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_STOP  = 3'd2;
   localparam logic [2:0] MODE_WSTOP = 3'd3;
   localparam logic [2:0] MODE_WMEAS = 3'd4;
   localparam logic [2:0] MODE_READY = 3'd5;
   localparam logic [2:0] MODE_READ  = 3'd6;
   localparam logic [2:0] MODE_ERROR = 3'd7;

   // Countdown kinds.
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_READY = 2'd1;
   localparam logic [1:0] KIND_STOPW = 2'd2;

   // Initialization levels.
   localparam logic [1:0] INIT_NONE    = 2'd0;
   localparam logic [1:0] INIT_PROCESS = 2'd1;
   localparam logic [1:0] INIT_DONE    = 2'd2;

   // Request types.
   localparam logic REQ_RUN  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_READ_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_STOP_WAIT     = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [15:0] READ_INTERVAL_RESET = 16'd5000;
   localparam logic [15:0] STOP_WAIT_RESET     = 16'd500;

   // Conversion scale factors.
   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [14:0] HUM_SCALE   = 15'd10000;
   localparam logic [13:0] TEMP_OFFSET = 14'd4500;
   localparam logic [16:0] FULL_SCALE  = 17'd65535;

   // Registered request after the input stage; products are formed on entry.
   typedef struct packed {
      logic        req_type;
      logic        xfer_ok;
      logic [14:0] co2;
      logic        co2_ok;
      logic [29:0] temp_prod;
      logic        temp_ok;
      logic [29:0] hum_prod;
      logic        hum_ok;
   } stage_type;

   // Floor of x / 65535 for x below 16384 * 65535. With q0 = x >> 16 the remainder
   // x - q0 * 65535 equals the low half plus q0, which stays below twice
   // the divisor, so one compare corrects the estimate.
   function automatic logic [13:0] div_full_scale(input logic [29:0] x);
      logic [13:0] q0;
      logic [16:0] rem;
      begin
         q0  = x[29:16];
         rem = {1'b0, x[15:0]} + {3'b000, q0};
         div_full_scale = (rem >= FULL_SCALE) ? q0 + 14'd1 : q0;
      end
   endfunction

endpackage

>>> rtl/co2_sensor_poll_controller.sv
// Top level of the CO2 sensor poll controller: sequencer, countdown and conversions.
`timescale 1ns / 1ps

// The controller takes one request per clock, a run step or a timer tick, and
// returns one result per request: the request is registered (with the
// conversion products already formed), then the mode update, countdown and
// division by full scale run in one pass into the result register. Both
// registers advance together, so a full stream sustains one transfer per
// cycle; the only hold-off on req_stall comes from rsp_stall.
// The configuration port is always ready and must only be written while no
// request is in flight.
module co2_sensor_poll_controller (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic        req_xfer_ok,
   input  logic [15:0] req_co2_raw,
   input  logic [15:0] req_temp_raw,
   input  logic [15:0] req_humidity_raw,
   // Result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_cmd_valid,
   output logic        [15:0] rsp_cmd_code,
   output logic               rsp_read_issued,
   output logic               rsp_step_ok,
   output logic        [2:0]  rsp_mode_now,
   output logic        [1:0]  rsp_init_progress,
   output logic        [14:0] rsp_co2_ppm,
   output logic signed [13:0] rsp_temp_centi,
   output logic        [12:0] rsp_humidity_centi,
   // Configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import cspc_pkg::*;

   // Configuration registers
   logic [15:0] read_interval_ff;
   logic [15:0] stop_wait_ff;

   // Input stage
   logic      s1_valid_ff;
   stage_type s1_ff;
   stage_type s1_in;
   logic      req_take;
   logic      advance;

   // Controller state
   logic [2:0]  mode_ff,     mode_in;
   logic [1:0]  init_ff,     init_in;
   logic [15:0] cnt_ff,      cnt_in;
   logic [1:0]  kind_ff,     kind_in;
   logic [14:0] co2_ff,      co2_in;
   logic [13:0] temp_ff,     temp_in;
   logic [12:0] hum_ff,      hum_in;

   // Result register
   logic        rsp_valid_ff;
   logic        cmd_valid_ff, cmd_valid_in;
   logic [15:0] cmd_code_ff,  cmd_code_in;
   logic        read_iss_ff,  read_iss_in;
   logic        step_ok_ff,   step_ok_in;

   // Conversion results
   logic [13:0] temp_quot;
   logic [13:0] hum_quot;

   // Handshake: both stages move together whenever the result slot frees up.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Form the conversion products as the request enters.
   always_comb begin
      s1_in.req_type  = req_type;
      s1_in.xfer_ok   = req_xfer_ok;
      s1_in.co2       = req_co2_raw[14:0];
      s1_in.co2_ok    = !req_co2_raw[15];
      s1_in.temp_prod = 30'(TEMP_SCALE * req_temp_raw[14:0]);
      s1_in.temp_ok   = !req_temp_raw[15];
      s1_in.hum_prod  = 30'(HUM_SCALE * req_humidity_raw[14:0]);
      s1_in.hum_ok    = !req_humidity_raw[15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= s1_in;
      end
   end

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         read_interval_ff <= READ_INTERVAL_RESET;
         stop_wait_ff     <= STOP_WAIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_READ_INTERVAL) begin
            read_interval_ff <= csr_wdata;
         end
         if (csr_index == CSR_STOP_WAIT) begin
            stop_wait_ff <= csr_wdata;
         end
      end
   end

   assign temp_quot = div_full_scale(s1_ff.temp_prod);
   assign hum_quot  = div_full_scale(s1_ff.hum_prod);

   // Step logic: countdown on ticks, mode sequencing on run steps.
   always_comb begin
      mode_in      = mode_ff;
      init_in      = init_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      co2_in       = co2_ff;
      temp_in      = temp_ff;
      hum_in       = hum_ff;
      cmd_valid_in = 1'b0;
      cmd_code_in  = 16'h0000;
      read_iss_in  = 1'b0;
      step_ok_in   = 1'b1;

      if (s1_ff.req_type == REQ_TICK) begin
         if (kind_ff == KIND_READY || kind_ff == KIND_STOPW) begin
            if (cnt_ff <= 16'd1) begin
               // Countdown expires: disarm and move the machine on.
               cnt_in  = 16'd0;
               kind_in = KIND_NONE;
               if (kind_ff == KIND_STOPW) begin
                  if (init_ff != INIT_DONE) begin
                     init_in = INIT_PROCESS;
                  end
                  mode_in = (mode_ff == MODE_WSTOP) ? MODE_IDLE : MODE_ERROR;
               end else begin
                  mode_in = (mode_ff == MODE_WMEAS) ? MODE_READ : MODE_ERROR;
               end
            end else begin
               cnt_in = cnt_ff - 16'd1;
            end
         end
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               if (init_ff != INIT_DONE) begin
                  mode_in = (init_ff == INIT_NONE) ? MODE_STOP : MODE_START;
               end
            end
            MODE_START: begin
               cmd_valid_in = 1'b1;
               cmd_code_in  = CMD_START;
               step_ok_in   = s1_ff.xfer_ok;
               if (s1_ff.xfer_ok) begin
                  cnt_in  = read_interval_ff;
                  kind_in = KIND_READY;
                  mode_in = MODE_WMEAS;
               end else begin
                  mode_in = MODE_ERROR;
               end
            end
            MODE_STOP: begin
               cmd_valid_in = 1'b1;
               cmd_code_in  = CMD_STOP;
               step_ok_in   = s1_ff.xfer_ok;
               if (s1_ff.xfer_ok) begin
                  cnt_in  = stop_wait_ff;
                  kind_in = KIND_STOPW;
                  mode_in = MODE_WSTOP;
               end else begin
                  cnt_in  = 16'd0;
                  kind_in = KIND_NONE;
                  mode_in = MODE_ERROR;
               end
            end
            MODE_READ: begin
               cmd_valid_in = 1'b1;
               cmd_code_in  = CMD_READ;
               read_iss_in  = s1_ff.xfer_ok;
               step_ok_in   = s1_ff.xfer_ok;
               if (s1_ff.xfer_ok) begin
                  // Words with the top bit set keep the previous value.
                  if (s1_ff.co2_ok) begin
                     co2_in = s1_ff.co2;
                  end
                  if (s1_ff.temp_ok) begin
                     temp_in = temp_quot - TEMP_OFFSET;
                  end
                  if (s1_ff.hum_ok) begin
                     hum_in = hum_quot[12:0];
                  end
                  cnt_in  = read_interval_ff;
                  kind_in = KIND_READY;
                  mode_in = MODE_WMEAS;
               end else begin
                  mode_in = MODE_ERROR;
               end
               // The first good read completes initialization and restarts
               // the sequence with a stop command.
               if (init_ff != INIT_DONE) begin
                  if (s1_ff.xfer_ok) begin
                     init_in = INIT_DONE;
                     mode_in = MODE_STOP;
                  end else begin
                     init_in = INIT_NONE;
                  end
               end
            end
            MODE_ERROR: begin
               cnt_in  = 16'd0;
               kind_in = KIND_NONE;
               mode_in = MODE_IDLE;
            end
            default: begin
               // Waiting and ready modes ignore run steps.
            end
         endcase
      end
   end

   // Controller state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         init_ff <= INIT_NONE;
         cnt_ff  <= 16'd0;
         kind_ff <= KIND_NONE;
         co2_ff  <= 15'd0;
         temp_ff <= 14'd0;
         hum_ff  <= 13'd0;
      end else if (advance) begin
         mode_ff <= mode_in;
         init_ff <= init_in;
         cnt_ff  <= cnt_in;
         kind_ff <= kind_in;
         co2_ff  <= co2_in;
         temp_ff <= temp_in;
         hum_ff  <= hum_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_valid_ff <= cmd_valid_in;
         cmd_code_ff  <= cmd_code_in;
         read_iss_ff  <= read_iss_in;
         step_ok_ff   <= step_ok_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cmd_valid      = cmd_valid_ff;
   assign rsp_cmd_code       = cmd_code_ff;
   assign rsp_read_issued    = read_iss_ff;
   assign rsp_step_ok        = step_ok_ff;
   assign rsp_mode_now       = mode_ff;
   assign rsp_init_progress  = init_ff;
   assign rsp_co2_ppm        = co2_ff;
   assign rsp_temp_centi     = temp_ff;
   assign rsp_humidity_centi = hum_ff;

`ifndef SYNTHESIS
   // The unused countdown kind is never armed.
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      kind_ff != 2'd3)
      else $error("countdown kind holds the unused code");

   // Each waiting mode always has its own countdown armed.
   a_wait_armed: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_WSTOP || kind_ff == KIND_STOPW) &&
      (mode_ff != MODE_WMEAS || kind_ff == KIND_READY))
      else $error("waiting mode without a matching countdown");

   // A result without a command carries no command word and no read.
   a_no_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cmd_valid |-> rsp_cmd_code == 16'h0000 && !rsp_read_issued)
      else $error("command fields set without a command");

   // The input stage only empties by moving into the result register.
   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("request dropped from the input stage");
`endif

endmodule
